// ===== hdl/psrl_pkg.sv =====
// Shared widths, codes and reset values for the palette scale/rotate/lookup block.
// No dependencies; compiled first.
package psrl_pkg;

    localparam int KIND_W      = 2;
    localparam int INDEX_W     = 8;
    localparam int COUNT_W     = 9;
    localparam int RAW_W       = 8;
    localparam int LEVEL_W     = 5;
    localparam int ENTRY_W     = 3 * LEVEL_W;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int MAX_LEVEL_W = 8;
    localparam int BRIGHT_W    = 9;

    // scaler datapath: num = raw * bright * 32, den = 100 * (max + 1)
    localparam int PROD_W = RAW_W + BRIGHT_W;
    localparam int NUM_W  = PROD_W + LEVEL_W;
    localparam int DEN_W  = 15;
    localparam int DSR_W  = DEN_W + LEVEL_W;

    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ROTATE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CONVERT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEVEL   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRANSPARENT = 2'd2;

    localparam logic [MAX_LEVEL_W-1:0] MAX_LEVEL_RST = 8'd63;
    localparam logic [BRIGHT_W-1:0]    BRIGHT_RST    = 9'd100;
    localparam logic                   TRANSP_RST    = 1'b1;

    localparam logic [LEVEL_W-1:0] LEVEL_SAT    = 5'd31;
    localparam logic [6:0]         PERCENT_BASE = 7'd100;
    // divider step that checks for a quotient of 32 or more
    localparam logic [2:0]         BIT_SAT      = 3'd5;

endpackage

// ===== hdl/psrl_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on psrl_pkg.
interface psrl_item_if;
    import psrl_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] index;
    logic [COUNT_W-1:0] count;
    logic [RAW_W-1:0]   red_raw;
    logic [RAW_W-1:0]   green_raw;
    logic [RAW_W-1:0]   blue_raw;

    modport source (output valid, kind, index, count, red_raw, green_raw, blue_raw,
                    input ready);
    modport sink   (input valid, kind, index, count, red_raw, green_raw, blue_raw,
                    output ready);
endinterface

interface psrl_result_if;
    import psrl_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic               pixel_written;

    modport source (output valid, red_level, green_level, blue_level, pixel_written,
                    input ready);
    modport sink   (input valid, red_level, green_level, blue_level, pixel_written,
                    output ready);
endinterface

// ===== hdl/psrl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psrl_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/palette_scale_rotate_lookup_core.sv =====
// Palette engine top level: load (scaled, saturated), rotate range, convert pixel.
// Convert: decode, convert and finish states, then the result is registered; no new item is taken before then.
// Load: each component runs through one shared compare/subtract unit, a saturation
//   check plus five quotient steps. Rotate of n entries: one entry per cycle through
//   the single read port; ranges under two entries skip the move.
// Reset: config registers return to max_level 63, brightness 100, transparency on; the
//   palette contents are undefined until loaded and are not cleared.
module palette_scale_rotate_lookup_core #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [psrl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [psrl_pkg::CFG_DATA_W-1:0]  cfg_data,
    psrl_item_if.sink                        item_ch,
    psrl_result_if.source                    result_ch
);
    import psrl_pkg::*;

    localparam int ADDR_W = $clog2(PALETTE_DEPTH);
    localparam int NDW0   = $clog2(PALETTE_DEPTH + 1);
    localparam int NDW    = (NDW0 > COUNT_W) ? NDW0 : COUNT_W;

    localparam logic [1:0] COMP_RED   = 2'd0;
    localparam logic [1:0] COMP_GREEN = 2'd1;
    localparam logic [1:0] COMP_BLUE  = 2'd2;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_DECODE   = 10'b0000000010,
        ST_CONV     = 10'b0000000100,
        ST_ROT_CAP  = 10'b0000001000,
        ST_ROT_MOVE = 10'b0000010000,
        ST_ROT_LAST = 10'b0000100000,
        ST_LD_MUL   = 10'b0001000000,
        ST_LD_DIV   = 10'b0010000000,
        ST_LD_WR    = 10'b0100000000,
        ST_FINISH   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [MAX_LEVEL_W-1:0] max_level_reg;
    logic [BRIGHT_W-1:0]    bright_reg;
    logic                   transp_reg;
    logic                   out_valid_reg, out_valid_next;

    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [RAW_W-1:0]   red_raw_reg, red_raw_next;
    logic [RAW_W-1:0]   green_raw_reg, green_raw_next;
    logic [RAW_W-1:0]   blue_raw_reg, blue_raw_next;

    logic [DEN_W-1:0]     den_reg, den_next;
    logic [NUM_W-1:0]     rem_reg, rem_next;
    logic [DSR_W-1:0]     dsr_reg, dsr_next;
    logic [LEVEL_W-2:0]   q_reg, q_next;
    logic [2:0]           bit_reg, bit_next;
    logic [1:0]           comp_reg, comp_next;
    logic [ADDR_W-1:0]    ptr_reg, ptr_next;
    logic [NDW-1:0]       moves_reg, moves_next;
    logic [ENTRY_W-1:0]   first_reg, first_next;
    logic [LEVEL_W-1:0]   r_lvl_reg, r_lvl_next;
    logic [LEVEL_W-1:0]   g_lvl_reg, g_lvl_next;
    logic [LEVEL_W-1:0]   b_lvl_reg, b_lvl_next;
    logic                 wr_reg, wr_next;
    logic [LEVEL_W-1:0]   out_red_reg, out_red_next;
    logic [LEVEL_W-1:0]   out_green_reg, out_green_next;
    logic [LEVEL_W-1:0]   out_blue_reg, out_blue_next;
    logic                 out_written_reg, out_written_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic [NDW-1:0]     idx_ext;
    logic [NDW-1:0]     cnt_ext;
    logic [NDW-1:0]     room;
    logic [NDW-1:0]     n_clamp;
    logic               idx_ok;
    logic [ADDR_W-1:0]  idx_addr;
    logic [DEN_W-1:0]   lvl_count;
    logic [DEN_W-1:0]   den_c;
    logic [RAW_W-1:0]   raw_sel;
    logic [PROD_W-1:0]  prod_c;
    logic [NUM_W:0]     diff_c;
    logic               ge;

    psrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // range checks and clamp for the current item
    assign idx_ext  = NDW'(idx_reg);
    assign cnt_ext  = NDW'(cnt_reg);
    assign idx_ok   = idx_ext < NDW'(PALETTE_DEPTH);
    assign room     = NDW'(PALETTE_DEPTH) - idx_ext;
    assign n_clamp  = (cnt_ext > room) ? room : cnt_ext;
    assign idx_addr = idx_ext[ADDR_W-1:0];

    assign lvl_count = DEN_W'(max_level_reg) + DEN_W'(1);
    assign den_c     = lvl_count * DEN_W'(PERCENT_BASE);

    always_comb
    begin
        unique case (comp_reg)
            COMP_RED:   raw_sel = red_raw_reg;
            COMP_GREEN: raw_sel = green_raw_reg;
            default:    raw_sel = blue_raw_reg;
        endcase
    end

    assign prod_c = PROD_W'(raw_sel) * PROD_W'(bright_reg);

    // shared compare/subtract unit of the restoring divider
    assign diff_c = {1'b0, rem_reg} - {{(NUM_W + 1 - DSR_W){1'b0}}, dsr_reg};
    assign ge     = !diff_c[NUM_W];

    assign item_ch.ready           = (state_reg == ST_IDLE);
    assign result_ch.valid         = out_valid_reg;
    assign result_ch.red_level     = out_red_reg;
    assign result_ch.green_level   = out_green_reg;
    assign result_ch.blue_level    = out_blue_reg;
    assign result_ch.pixel_written = out_written_reg;

    always_comb
    begin
        logic               done;
        logic [LEVEL_W-1:0] level_c;

        done             = 1'b0;
        level_c          = '0;
        state_next       = state_reg;
        out_valid_next   = out_valid_reg && !result_ch.ready;
        kind_next        = kind_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        red_raw_next     = red_raw_reg;
        green_raw_next   = green_raw_reg;
        blue_raw_next    = blue_raw_reg;
        den_next         = den_reg;
        rem_next         = rem_reg;
        dsr_next         = dsr_reg;
        q_next           = q_reg;
        bit_next         = bit_reg;
        comp_next        = comp_reg;
        ptr_next         = ptr_reg;
        moves_next       = moves_reg;
        first_next       = first_reg;
        r_lvl_next       = r_lvl_reg;
        g_lvl_next       = g_lvl_reg;
        b_lvl_next       = b_lvl_reg;
        wr_next          = wr_reg;
        out_red_next     = out_red_reg;
        out_green_next   = out_green_reg;
        out_blue_next    = out_blue_reg;
        out_written_next = out_written_reg;
        ram_we           = 1'b0;
        ram_waddr        = ptr_reg;
        ram_wdata        = ram_rdata;
        ram_raddr        = ptr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_ch.valid)
                begin
                    kind_next      = item_ch.kind;
                    idx_next       = item_ch.index;
                    cnt_next       = item_ch.count;
                    red_raw_next   = item_ch.red_raw;
                    green_raw_next = item_ch.green_raw;
                    blue_raw_next  = item_ch.blue_raw;
                    state_next     = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                ram_raddr  = idx_addr;
                r_lvl_next = '0;
                g_lvl_next = '0;
                b_lvl_next = '0;
                wr_next    = 1'b0;
                den_next   = den_c;
                comp_next  = COMP_RED;
                ptr_next   = idx_addr;
                moves_next = n_clamp - NDW'(1);
                unique case (kind_reg)
                    KIND_LOAD:    state_next = idx_ok ? ST_LD_MUL : ST_FINISH;
                    KIND_ROTATE:  state_next = (idx_ok && n_clamp > NDW'(1)) ? ST_ROT_CAP
                                                                            : ST_FINISH;
                    KIND_CONVERT: state_next = ST_CONV;
                    KIND_NONE:    state_next = ST_FINISH;
                endcase
            end
            ST_CONV:
            begin
                if (!(idx_reg == '0 && transp_reg))
                begin
                    wr_next = 1'b1;
                    if (idx_ok)
                    begin
                        r_lvl_next = ram_rdata[ENTRY_W-1 -: LEVEL_W];
                        g_lvl_next = ram_rdata[LEVEL_W +: LEVEL_W];
                        b_lvl_next = ram_rdata[LEVEL_W-1:0];
                    end
                end
                state_next = ST_FINISH;
            end
            ST_ROT_CAP:
            begin
                first_next = ram_rdata;
                ram_raddr  = ptr_reg + ADDR_W'(1);
                state_next = ST_ROT_MOVE;
            end
            ST_ROT_MOVE:
            begin
                // read runs one entry ahead of the write
                ram_we     = 1'b1;
                ram_waddr  = ptr_reg;
                ram_wdata  = ram_rdata;
                ptr_next   = ptr_reg + ADDR_W'(1);
                moves_next = moves_reg - NDW'(1);
                if (moves_reg == NDW'(1))
                begin
                    state_next = ST_ROT_LAST;
                end
                else
                begin
                    ram_raddr = ptr_reg + ADDR_W'(2);
                end
            end
            ST_ROT_LAST:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ptr_reg;
                ram_wdata  = first_reg;
                state_next = ST_FINISH;
            end
            ST_LD_MUL:
            begin
                rem_next   = {prod_c, {LEVEL_W{1'b0}}};
                dsr_next   = {den_reg, {LEVEL_W{1'b0}}};
                bit_next   = BIT_SAT;
                q_next     = '0;
                state_next = ST_LD_DIV;
            end
            ST_LD_DIV:
            begin
                dsr_next = dsr_reg >> 1;
                if (bit_reg == BIT_SAT)
                begin
                    if (ge)
                    begin
                        level_c = LEVEL_SAT;
                        done    = 1'b1;
                    end
                    else
                    begin
                        bit_next = bit_reg - 3'd1;
                    end
                end
                else
                begin
                    if (ge)
                    begin
                        rem_next = diff_c[NUM_W-1:0];
                    end
                    q_next  = {q_reg[LEVEL_W-3:0], ge};
                    level_c = {q_reg, ge};
                    if (bit_reg == '0)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        bit_next = bit_reg - 3'd1;
                    end
                end
                if (done)
                begin
                    unique case (comp_reg)
                        COMP_RED:   r_lvl_next = level_c;
                        COMP_GREEN: g_lvl_next = level_c;
                        default:    b_lvl_next = level_c;
                    endcase
                    if (comp_reg == COMP_BLUE)
                    begin
                        state_next = ST_LD_WR;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = ST_LD_MUL;
                    end
                end
            end
            ST_LD_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_addr;
                ram_wdata  = {r_lvl_reg, g_lvl_reg, b_lvl_reg};
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result_ch.ready)
                begin
                    out_red_next     = r_lvl_reg;
                    out_green_next   = g_lvl_reg;
                    out_blue_next    = b_lvl_reg;
                    out_written_next = wr_reg;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            max_level_reg <= MAX_LEVEL_RST;
            bright_reg    <= BRIGHT_RST;
            transp_reg    <= TRANSP_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAX_LEVEL:   max_level_reg <= cfg_data[MAX_LEVEL_W-1:0];
                    CFG_BRIGHTNESS:  bright_reg    <= cfg_data[BRIGHT_W-1:0];
                    CFG_TRANSPARENT: transp_reg    <= cfg_data[0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        idx_reg         <= idx_next;
        cnt_reg         <= cnt_next;
        red_raw_reg     <= red_raw_next;
        green_raw_reg   <= green_raw_next;
        blue_raw_reg    <= blue_raw_next;
        den_reg         <= den_next;
        rem_reg         <= rem_next;
        dsr_reg         <= dsr_next;
        q_reg           <= q_next;
        bit_reg         <= bit_next;
        comp_reg        <= comp_next;
        ptr_reg         <= ptr_next;
        moves_reg       <= moves_next;
        first_reg       <= first_next;
        r_lvl_reg       <= r_lvl_next;
        g_lvl_reg       <= g_lvl_next;
        b_lvl_reg       <= b_lvl_next;
        wr_reg          <= wr_next;
        out_red_reg     <= out_red_next;
        out_green_reg   <= out_green_next;
        out_blue_reg    <= out_blue_next;
        out_written_reg <= out_written_next;
    end

    // one item in flight: no transfer right after a transfer
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (item_ch.valid && item_ch.ready) |=> !item_ch.ready)
        else $error("input accepted while an item is in flight");

    // a new result only comes out of the finish step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result valid raised outside the finish step");

    // rotate lookahead read never hits the entry being overwritten
    a_rot_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROT_MOVE && moves_reg != NDW'(1)) |-> (ram_raddr != ram_waddr))
        else $error("rotate read and write address collide");

    // restoring divider invariant after the saturation check
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LD_DIV && bit_reg != BIT_SAT) |-> (rem_reg < {dsr_reg, 1'b0}))
        else $error("divider remainder out of range");

endmodule
